>>> hdl/rpp_pkg.sv
// Shared types, constants and the arctangent table for the point rotation unit.
// Used by rpp_cordic and rotate_point_about_pivot_unit; depends on nothing else.
`default_nettype none

package rpp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEPS        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   // vector and angle datapath widths
   localparam int XW = 52;
   localparam int ZW = 34;

   localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic        [29:0]   INV_GAIN    = 30'd652032874;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               zero;
   } side_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      side_type             side;
   } vec_type;

   // atan(2^-i) in Q.30, truncated
   function automatic logic [29:0] atan_q30(input int unsigned i);
      logic [29:0] a;
      case (i)
         0:  a = 30'h3243F6A8;
         1:  a = 30'h1DAC6705;
         2:  a = 30'h0FADBAFC;
         3:  a = 30'h07F56EA6;
         4:  a = 30'h03FEAB76;
         5:  a = 30'h01FFD55B;
         6:  a = 30'h00FFFAAA;
         7:  a = 30'h007FFF55;
         8:  a = 30'h003FFFEA;
         9:  a = 30'h001FFFFD;
         10: a = 30'h000FFFFF;
         11: a = 30'h0007FFFF;
         12: a = 30'h0003FFFF;
         13: a = 30'h0001FFFF;
         14: a = 30'h0000FFFF;
         15: a = 30'h00007FFF;
         16: a = 30'h00003FFF;
         17: a = 30'h00001FFF;
         18: a = 30'h00000FFF;
         19: a = 30'h000007FF;
         20: a = 30'h000003FF;
         21: a = 30'h000001FF;
         22: a = 30'h000000FF;
         23: a = 30'h0000007F;
         24: a = 30'h0000003F;
         25: a = 30'h0000001F;
         26: a = 30'h0000000F;
         27: a = 30'h00000008;
         28: a = 30'h00000004;
         29: a = 30'h00000002;
         30: a = 30'h00000001;
         default: a = 30'h00000000;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

>>> hdl/rpp_cordic.sv
// Pipelined CORDIC rotation: one iteration per register stage, STEPS stages.
// Depends on rpp_pkg for the vector type, widths and the arctangent table.
`default_nettype none

module rpp_cordic (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rpp_pkg::vec_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rpp_pkg::vec_type     out_data
);
   import rpp_pkg::*;

   vec_type    stage_ff [STEPS];
   vec_type    stage_in [STEPS];
   logic       valid_ff [STEPS];
   logic [STEPS:0] ready;

   assign ready[STEPS] = out_ready;
   assign in_ready     = ready[0];

   generate
      for (genvar k = 0; k < STEPS; k++) begin : g_iter
         localparam logic signed [ZW-1:0] ATAN_K = ZW'(atan_q30(k));
         vec_type              prev;
         logic                 prev_valid;
         logic signed [XW-1:0] xp, yp, xs, ys;
         logic signed [ZW-1:0] zp;

         if (k == 0) begin : g_head
            assign prev       = in_data;
            assign prev_valid = in_valid;
         end else begin : g_body
            assign prev       = stage_ff[k-1];
            assign prev_valid = valid_ff[k-1];
         end

         assign ready[k] = !valid_ff[k] || ready[k+1];
         assign xp = prev.x;
         assign yp = prev.y;
         assign zp = prev.z;
         assign xs = xp >>> k;
         assign ys = yp >>> k;

         always_comb begin
            stage_in[k] = prev;
            if (!zp[ZW-1]) begin
               stage_in[k].x = xp - ys;
               stage_in[k].y = yp + xs;
               stage_in[k].z = zp - ATAN_K;
            end else begin
               stage_in[k].x = xp + ys;
               stage_in[k].y = yp - xs;
               stage_in[k].z = zp + ATAN_K;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (ready[k] && prev_valid) begin
               stage_ff[k] <= stage_in[k];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[STEPS-1];
   assign out_data  = stage_ff[STEPS-1];

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("cordic output changed while stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("cordic lost an entering request");

endmodule

`default_nettype wire

>>> hdl/rotate_point_about_pivot_unit.sv
// Top level of the point rotation unit: angle reduction, gain multiply, CORDIC, rounding, clamp.
// Depends on rpp_pkg and rpp_cordic.
//
// Rotates a Q16.16 point about a Q16.16 pivot by a signed Q3.16 angle in radians.
// Request channel: req_valid/req_ready with point, pivot and angle fields.
// Response channel: rsp_valid/rsp_ready with new_x, new_y and a saturated flag.
// A request is taken when valid and ready are both high at a rising clock edge.
// From request to response, a request passes through these stages in order:
// three front stages (pivot subtract and angle reduction, split gain
// multiply with quadrant fold, partial-product merge), one stage per CORDIC
// iteration, a rounding stage and the saturating output register.
// Throughput: one request per cycle while rsp_ready is high; every stage is a register
// with its own valid bit, so the pipeline of CORDIC iterations sets the depth, not the rate.
// When the receiver stalls, the output register holds its response and the
// stages behind it keep filling empty slots; req_ready drops only once every
// stage holds a request. A zero angle returns the point unchanged.
// Reset (synchronous, active high) empties every stage; no response is lost
// or repeated across a stall.
`default_nettype none

module rotate_point_about_pivot_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_point_x,
   input  wire logic [31:0] req_point_y,
   input  wire logic [31:0] req_pivot_x,
   input  wire logic [31:0] req_pivot_y,
   input  wire logic [19:0] req_angle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_new_x,
   output logic [31:0]      rsp_new_y,
   output logic             rsp_saturated
);
   import rpp_pkg::*;

   // stage A: pivot subtract, reduce angle into [-pi, pi]
   logic                 a_valid_ff;
   logic                 a_ready;
   logic signed [32:0]   a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic signed [ZW-1:0] a_z_ff, a_z_in, a_z0;
   side_type             a_side_ff, a_side_in;

   // stage B: split gain products, fold into [-pi/2, pi/2]
   logic                 b_valid_ff;
   logic                 b_ready;
   logic signed [47:0]   b_xh_ff, b_yh_ff, b_xh_in, b_yh_in;
   logic        [45:0]   b_xl_ff, b_yl_ff, b_xl_in, b_yl_in;
   logic signed [ZW-1:0] b_z_ff, b_z_in;
   logic                 b_neg_ff, b_neg_in;
   side_type             b_side_ff;

   // stage C: merge products, apply fold negation
   logic                 c_valid_ff;
   logic                 c_ready;
   vec_type              c_vec_ff, c_vec_in;
   logic signed [63:0]   c_fx, c_fy;
   logic signed [XW-1:0] c_x, c_y;

   logic                 k_valid, k_in_ready;
   vec_type              k_data;

   // stage R: round to Q.16
   logic                 r_valid_ff;
   logic                 r_ready;
   logic signed [XW-17:0] r_x_ff, r_y_ff, r_x_in, r_y_in;
   side_type             r_side_ff;
   logic signed [XW-1:0] r_tx, r_ty;

   // output register
   logic                 o_ready;
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   logic signed [XW-16:0] o_sx, o_sy;
   logic                 o_ovx, o_ovy;

   assign o_ready   = !rsp_valid_ff || rsp_ready;
   assign r_ready   = !r_valid_ff || o_ready;
   assign c_ready   = !c_valid_ff || k_in_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready;

   // stage A
   assign a_z0 = {req_angle, 14'b0};

   always_comb begin
      a_dx_in = {req_point_x[31], req_point_x} - {req_pivot_x[31], req_pivot_x};
      a_dy_in = {req_point_y[31], req_point_y} - {req_pivot_y[31], req_pivot_y};
      if (a_z0 > PI_Q30) begin
         a_z_in = a_z0 - TWO_PI_Q30;
      end else if (a_z0 < -PI_Q30) begin
         a_z_in = a_z0 + TWO_PI_Q30;
      end else begin
         a_z_in = a_z0;
      end
      a_side_in.px   = req_point_x;
      a_side_in.py   = req_point_y;
      a_side_in.cx   = req_pivot_x;
      a_side_in.cy   = req_pivot_y;
      a_side_in.zero = (req_angle == 20'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_valid) begin
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_z_ff    <= a_z_in;
         a_side_ff <= a_side_in;
      end
   end

   // stage B
   always_comb begin
      b_xl_in = a_dx_ff[15:0] * INV_GAIN;
      b_yl_in = a_dy_ff[15:0] * INV_GAIN;
      b_xh_in = $signed(a_dx_ff[32:16]) * $signed({1'b0, INV_GAIN});
      b_yh_in = $signed(a_dy_ff[32:16]) * $signed({1'b0, INV_GAIN});
      if (a_z_ff > HALF_PI_Q30) begin
         b_z_in   = a_z_ff - PI_Q30;
         b_neg_in = 1'b1;
      end else if (a_z_ff < -HALF_PI_Q30) begin
         b_z_in   = a_z_ff + PI_Q30;
         b_neg_in = 1'b1;
      end else begin
         b_z_in   = a_z_ff;
         b_neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_xh_ff   <= b_xh_in;
         b_yh_ff   <= b_yh_in;
         b_xl_ff   <= b_xl_in;
         b_yl_ff   <= b_yl_in;
         b_z_ff    <= b_z_in;
         b_neg_ff  <= b_neg_in;
         b_side_ff <= a_side_ff;
      end
   end

   // stage C
   assign c_fx = $signed({b_xh_ff, 16'b0}) + $signed({18'b0, b_xl_ff});
   assign c_fy = $signed({b_yh_ff, 16'b0}) + $signed({18'b0, b_yl_ff});
   assign c_x  = {{2{c_fx[63]}}, c_fx[63:14]};
   assign c_y  = {{2{c_fy[63]}}, c_fy[63:14]};

   always_comb begin
      c_vec_in.x    = b_neg_ff ? -c_x : c_x;
      c_vec_in.y    = b_neg_ff ? -c_y : c_y;
      c_vec_in.z    = b_z_ff;
      c_vec_in.side = b_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) begin
         c_vec_ff <= c_vec_in;
      end
   end

   rpp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_ready  (k_in_ready),
      .in_data   (c_vec_ff),
      .out_valid (k_valid),
      .out_ready (r_ready),
      .out_data  (k_data)
   );

   // stage R
   assign r_tx   = k_data.x + XW'(32768);
   assign r_ty   = k_data.y + XW'(32768);
   assign r_x_in = r_tx[XW-1:16];
   assign r_y_in = r_ty[XW-1:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (r_ready) begin
         r_valid_ff <= k_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (r_ready && k_valid) begin
         r_x_ff    <= r_x_in;
         r_y_ff    <= r_y_in;
         r_side_ff <= k_data.side;
      end
   end

   // output: add pivot back, clamp, bypass on zero angle
   assign o_sx  = {r_x_ff[XW-17], r_x_ff} + (XW-15)'(r_side_ff.cx);
   assign o_sy  = {r_y_ff[XW-17], r_y_ff} + (XW-15)'(r_side_ff.cy);
   assign o_ovx = (o_sx[XW-16:31] != {(XW-46){o_sx[31]}});
   assign o_ovy = (o_sy[XW-16:31] != {(XW-46){o_sy[31]}});

   always_comb begin
      if (r_side_ff.zero) begin
         rsp_x_in   = r_side_ff.px;
         rsp_y_in   = r_side_ff.py;
         rsp_sat_in = 1'b0;
      end else begin
         rsp_x_in   = o_ovx ? (o_sx[XW-16] ? COORD_MIN : COORD_MAX) : o_sx[31:0];
         rsp_y_in   = o_ovy ? (o_sy[XW-16] ? COORD_MIN : COORD_MAX) : o_sy[31:0];
         rsp_sat_in = o_ovx || o_ovy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_ready) begin
         rsp_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && r_valid_ff) begin
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_x     = rsp_x_ff;
   assign rsp_new_y     = rsp_y_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (a_side_ff.zero == (a_z_ff == '0)))
      else $error("zero-angle flag disagrees with reduced angle");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_z_ff <= HALF_PI_Q30) && (b_z_ff >= -HALF_PI_Q30))
      else $error("folded angle outside half-pi range");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> (rsp_x_ff == COORD_MAX) || (rsp_x_ff == COORD_MIN)
         || (rsp_y_ff == COORD_MAX) || (rsp_y_ff == COORD_MIN))
      else $error("saturated flag without a clamped coordinate");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !a_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
